### src/cvd_pkg.sv
`default_nettype none
package cvd_pkg;

	localparam logic [2:0] CFG_NUM_STATES  = 3'd0;
	localparam logic [2:0] CFG_SIMPLE_MODE = 3'd1;
	localparam logic [2:0] CFG_SAME_SCORE  = 3'd2;
	localparam logic [2:0] CFG_CHANGE_SCORE = 3'd3;
	localparam logic [2:0] CFG_USE_WEIGHTS = 3'd4;

	localparam logic KIND_TABLE = 1'b0;
	localparam logic KIND_NODE  = 1'b1;

	localparam logic signed [47:0] S48_MAX = {1'b0, {47{1'b1}}};
	localparam logic signed [47:0] S48_MIN = {1'b1, {47{1'b0}}};

	typedef struct packed {
		logic               kind;
		logic [3:0]         from_state;
		logic [3:0]         to_state;
		logic signed [31:0] score;
		logic signed [31:0] prior;
		logic signed [15:0] link_weight;
		logic               first_node;
		logic               last_node;
	} in_t;

	typedef struct packed {
		logic [5:0]         node_index;
		logic [3:0]         best_state;
		logic signed [47:0] best_total;
		logic               last;
	} out_t;

	function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
		logic signed [47:0] r;
		if (v[48] != v[47]) begin
			r = v[48] ? S48_MIN : S48_MAX;
		end else begin
			r = v[47:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

### src/cvd_front.sv
`default_nettype none
module cvd_front import cvd_pkg::*; #(
	parameter int MAX_STATES = 16,
	parameter int SW = 4
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire in_t           item,
	input  wire logic [SW-1:0] km1,
	output logic               busy,
	output logic               q_valid,
	output in_t                q_head,
	input  wire logic          q_pop
);

	in_t        fifo_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       keep;
	logic       push;

	always_comb begin
		if (item.kind == KIND_TABLE) begin
			keep = ({1'b0, item.from_state} < 5'(MAX_STATES)) &&
				({1'b0, item.to_state} < 5'(MAX_STATES));
		end else begin
			keep = item.to_state <= 4'(km1);
		end
	end

	assign busy    = cnt_q == 2'd2;
	assign push    = start && !busy && keep;
	assign q_valid = cnt_q != 2'd0;
	assign q_head  = fifo_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (q_pop) begin
				rd_q <= !rd_q;
			end
			case ({push, q_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

### src/cvd_back.sv
`default_nettype none
module cvd_back import cvd_pkg::*; #(
	parameter int MAX_STATES = 16,
	parameter int MAX_NODES = 64,
	parameter int SW = 4,
	parameter int NW = 6
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               q_valid,
	input  wire in_t                q_head,
	output logic                    q_pop,
	input  wire logic [SW-1:0]      km1,
	input  wire logic               simple_mode,
	input  wire logic signed [31:0] same_score,
	input  wire logic signed [31:0] change_score,
	input  wire logic               use_weights,
	output logic                    strobe,
	output out_t                    result
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SCAN = 3'd1;
	localparam logic [2:0] ST_WB   = 3'd2;
	localparam logic [2:0] ST_DONE = 3'd3;
	localparam logic [2:0] ST_ARG  = 3'd4;
	localparam logic [2:0] ST_EMIT = 3'd5;
	localparam logic [2:0] ST_STEP = 3'd6;

	logic [2:0]         state_q;
	in_t                cmd_q;
	logic [NW-1:0]      idx_q;
	logic [NW-1:0]      node_cnt_q;
	logic [SW-1:0]      l_q;
	logic               issue_q;
	logic               valid_s1, valid_s2, valid_s3;
	logic [SW-1:0]      l_s1, l_s2, l_s3;
	logic signed [47:0] prev_s1, prev_s2;
	logic signed [31:0] tab_s1;
	logic signed [39:0] t_s2;
	logic signed [47:0] v_s3;
	logic signed [47:0] best_q;
	logic [SW-1:0]      arg_q;
	logic [NW-1:0]      i_q;
	logic [SW-1:0]      s_q;
	logic [SW-1:0]      bp_rd;
	logic signed [47:0] prev_q [MAX_STATES];
	logic signed [47:0] cur_q [MAX_STATES];
	logic signed [31:0] tab_mem [1 << (2 * SW)];
	logic [SW-1:0]      bp_mem [1 << (NW + SW)];

	logic [NW-1:0]      idx_in;
	logic signed [31:0] sel;
	logic signed [47:0] prod;
	logic               arg_upd;
	logic               tab_we;
	logic               bp_we;

	assign idx_in  = q_head.first_node ? '0 : node_cnt_q;
	assign q_pop   = (state_q == ST_IDLE) && q_valid;
	assign tab_we  = q_pop && (q_head.kind == KIND_TABLE);
	assign bp_we   = state_q == ST_WB;
	assign arg_upd = (l_q == '0) || (cur_q[l_q] > best_q);

	always_comb begin
		if (simple_mode) begin
			sel = (l_s1 == cmd_q.to_state[SW-1:0]) ? same_score : change_score;
		end else begin
			sel = tab_s1;
		end
		prod = sel * cmd_q.link_weight;
	end

	always_ff @(posedge clk) begin
		if (tab_we) begin
			tab_mem[{q_head.from_state[SW-1:0], q_head.to_state[SW-1:0]}] <= q_head.score;
		end
		tab_s1 <= tab_mem[{l_q, cmd_q.to_state[SW-1:0]}];
		if (bp_we) begin
			bp_mem[{idx_q, cmd_q.to_state[SW-1:0]}] <= arg_q;
		end
		bp_rd <= bp_mem[{i_q, s_q}];
	end

	// scan pipeline: read, weight, add, compare
	always_ff @(posedge clk) begin
		l_s1    <= l_q;
		prev_s1 <= prev_q[l_q];
		l_s2    <= l_s1;
		prev_s2 <= prev_s1;
		t_s2    <= use_weights ? prod[47:8] : 40'(sel);
		l_s3    <= l_s2;
		v_s3    <= sat48({prev_s2[47], prev_s2} + {{9{t_s2[39]}}, t_s2});
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_head.kind == KIND_NODE && idx_in == '0) begin
			cur_q[q_head.to_state[SW-1:0]] <= 48'({{16{q_head.score[31]}}, q_head.score} +
				{{16{q_head.prior[31]}}, q_head.prior});
		end else if (state_q == ST_WB) begin
			cur_q[cmd_q.to_state[SW-1:0]] <= sat48({best_q[47], best_q} +
				{{17{cmd_q.score[31]}}, cmd_q.score});
		end
		if (state_q == ST_DONE && cmd_q.to_state == 4'(km1)) begin
			prev_q <= cur_q;
		end
		if (q_pop) begin
			cmd_q <= q_head;
			idx_q <= idx_in;
		end
		if (state_q == ST_SCAN && valid_s3 && ((l_s3 == '0) || (v_s3 > best_q))) begin
			best_q <= v_s3;
			arg_q  <= l_s3;
		end else if (state_q == ST_ARG && arg_upd) begin
			best_q <= cur_q[l_q];
			arg_q  <= l_q;
		end
		if (state_q == ST_ARG && l_q == km1) begin
			i_q <= idx_q;
			s_q <= arg_upd ? l_q : arg_q;
		end else if (state_q == ST_STEP) begin
			i_q <= i_q - 1'b1;
			s_q <= ({1'b0, bp_rd} < (SW + 1)'(MAX_STATES)) ? bp_rd : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			node_cnt_q <= '0;
			l_q        <= '0;
			issue_q    <= 1'b0;
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			valid_s3   <= 1'b0;
		end else begin
			valid_s1 <= (state_q == ST_SCAN) && issue_q;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop && q_head.kind == KIND_NODE) begin
						l_q <= '0;
						if (idx_in == '0) begin
							state_q <= ST_DONE;
						end else begin
							issue_q <= 1'b1;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (issue_q) begin
						if (l_q == km1) begin
							issue_q <= 1'b0;
						end else begin
							l_q <= l_q + 1'b1;
						end
					end
					if (valid_s3 && l_s3 == km1) begin
						state_q <= ST_WB;
					end
				end
				ST_WB: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					l_q <= '0;
					if (cmd_q.to_state != 4'(km1)) begin
						node_cnt_q <= idx_q;
						state_q    <= ST_IDLE;
					end else if (!cmd_q.last_node) begin
						node_cnt_q <= (idx_q == NW'(MAX_NODES - 1)) ? idx_q : idx_q + 1'b1;
						state_q    <= ST_IDLE;
					end else begin
						node_cnt_q <= '0;
						state_q    <= ST_ARG;
					end
				end
				ST_ARG: begin
					if (l_q == km1) begin
						state_q <= ST_EMIT;
					end else begin
						l_q <= l_q + 1'b1;
					end
				end
				ST_EMIT: begin
					state_q <= (i_q == '0) ? ST_IDLE : ST_STEP;
				end
				ST_STEP: begin
					state_q <= ST_EMIT;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign strobe            = state_q == ST_EMIT;
	assign result.node_index = 6'(i_q);
	assign result.best_state = 4'(s_q);
	assign result.best_total = best_q;
	assign result.last       = i_q == '0;

endmodule
`default_nettype wire

### src/chain_viterbi_map_decoder.sv
`default_nettype none
// max-sum viterbi decoder over a chain of nodes
// input channel: a word is taken on a clock edge with start high and busy low;
// kind 0 words load one transition table entry, kind 1 words give the unary
// score of one state of the current node
// config: cfg_we with cfg_index and cfg_data writes one register; the user must
// write only while idle (the block does not enforce it); a front stage filters
// words into a two-entry queue, busy high when full; the back end takes one word
// at a time from it; a table word is written into the table when taken, a
// first-node state is stored directly, and a later-node state scans the previous
// states one per cycle via the shared table read, weight multiply and saturating add
// the last state of the last node adds the final argmax over all states, then
// one result per node (backpointer memory read between results), last node first
// each result word is shown for exactly one cycle with strobe high; the receiver
// cannot stall, so it must take every strobed word
// reset clears control state and the node counter; score, table and backpointer
// stores hold no value until written
module chain_viterbi_map_decoder import cvd_pkg::*; #(
	parameter int MAX_STATES = 16,
	parameter int MAX_NODES = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire in_t         item,
	output logic             strobe,
	output out_t             result,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	localparam int SW = $clog2(MAX_STATES);
	localparam int NW = $clog2(MAX_NODES);

	logic [4:0]         num_states_q;
	logic               simple_mode_q;
	logic signed [31:0] same_score_q;
	logic signed [31:0] change_score_q;
	logic               use_weights_q;
	logic [SW-1:0]      km1;
	logic               q_valid;
	logic               q_pop;
	in_t                q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_states_q   <= 5'd16;
			simple_mode_q  <= 1'b0;
			same_score_q   <= '0;
			change_score_q <= '0;
			use_weights_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_NUM_STATES:   num_states_q   <= cfg_data[4:0];
				CFG_SIMPLE_MODE:  simple_mode_q  <= cfg_data[0];
				CFG_SAME_SCORE:   same_score_q   <= cfg_data;
				CFG_CHANGE_SCORE: change_score_q <= cfg_data;
				CFG_USE_WEIGHTS:  use_weights_q  <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		if (num_states_q == 5'd0) begin
			km1 = '0;
		end else if (num_states_q > 5'(MAX_STATES)) begin
			km1 = SW'(MAX_STATES - 1);
		end else begin
			km1 = SW'(num_states_q - 5'd1);
		end
	end

	cvd_front #(
		.MAX_STATES(MAX_STATES),
		.SW(SW)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.item(item),
		.km1(km1),
		.busy(busy),
		.q_valid(q_valid),
		.q_head(q_head),
		.q_pop(q_pop)
	);

	cvd_back #(
		.MAX_STATES(MAX_STATES),
		.MAX_NODES(MAX_NODES),
		.SW(SW),
		.NW(NW)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_valid),
		.q_head(q_head),
		.q_pop(q_pop),
		.km1(km1),
		.simple_mode(simple_mode_q),
		.same_score(same_score_q),
		.change_score(change_score_q),
		.use_weights(use_weights_q),
		.strobe(strobe),
		.result(result)
	);

endmodule
`default_nettype wire
